>>> hdl/heading_pid_differential_drive_core_macros.svh
// assertion macros for the heading pid differential drive core
`ifndef HEADING_PID_DIFFERENTIAL_DRIVE_CORE_MACROS_SVH
`define HEADING_PID_DIFFERENTIAL_DRIVE_CORE_MACROS_SVH

// property that holds at every clock edge outside reset
`define HPDD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that forces a consequence in the next cycle
`define HPDD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/hpdd_pkg.sv
// shared types and constants of the heading pid differential drive core
package hpdd_pkg;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_HEAD = 3'd1;
    localparam logic [2:0] OP_DIST = 3'd2;
    localparam logic [2:0] OP_STOP = 3'd3;
    localparam logic [2:0] OP_END  = 3'd4;
    localparam logic [2:0] OP_NONE = 3'd5;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic [2:0]         op;
        logic [11:0]        heading;
        logic               obstacle;
        logic signed [23:0] distance;
    } mid_t;

    typedef struct packed {
        logic signed [8:0] right_speed;
        logic signed [8:0] left_speed;
        logic              speeds_valid;
        logic              translation_done;
        logic              rotation_done;
        logic              match_over;
        logic              stop_active;
    } res_t;

    typedef struct packed {
        logic               stop_enable;
        logic signed [15:0] gain_prop;
        logic signed [15:0] gain_integ;
        logic signed [15:0] gain_deriv;
        logic [6:0]         turn_speed_limit;
        logic [6:0]         cruise_speed;
        logic [6:0]         top_speed;
        logic [11:0]        heading_tolerance;
    } cfg_t;

endpackage

>>> hdl/hpdd_queue.sv
// small register queue for words between stages
module hpdd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic [CW-1:0]    count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = push && (count_reg < CW'(DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

>>> hdl/hpdd_front.sv
// front end: accepts commands, classifies them and reduces the heading field
module hpdd_front #(
    parameter int HEADING_RANGE = 4096,
    parameter int CW            = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          command,
    input  logic [11:0]         heading_now,
    input  logic                obstacle_seen,
    input  logic [11:0]         heading_goal,
    input  logic signed [23:0]  distance_goal,
    input  logic [CW-1:0]       mid_count,
    output logic                mid_push,
    output hpdd_pkg::mid_t      mid_word
);

    localparam logic [20:0] RECIP   = 21'((1 << 24) / HEADING_RANGE);
    localparam logic [16:0] RANGE17 = 17'(HEADING_RANGE);

    logic           va_reg;
    hpdd_pkg::mid_t fa_word_reg, fa_word_next;
    logic [32:0]    fa_prod_reg;
    logic           accept;
    logic [11:0]    sel_x;
    logic [8:0]     quot;
    logic [25:0]    qr_full;
    logic [11:0]    rem_raw;

    assign full   = ({1'b0, mid_count} + {{CW{1'b0}}, va_reg}) >= (CW + 1)'(hpdd_pkg::MID_DEPTH);
    assign accept = push && !full;

    always_comb
    begin
        fa_word_next.obstacle = obstacle_seen;
        fa_word_next.distance = distance_goal;
        unique case (command) inside
            hpdd_pkg::OP_TICK, hpdd_pkg::OP_HEAD, hpdd_pkg::OP_DIST,
            hpdd_pkg::OP_STOP, hpdd_pkg::OP_END:
                fa_word_next.op = command;
            default:
                fa_word_next.op = hpdd_pkg::OP_NONE;
        endcase
        sel_x = (command == hpdd_pkg::OP_HEAD) ? heading_goal : heading_now;
        fa_word_next.heading = sel_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= accept;
        end
    end

    // quotient estimate by reciprocal, at most one short
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fa_word_reg <= fa_word_next;
            fa_prod_reg <= {21'b0, sel_x} * {12'b0, RECIP};
        end
    end

    assign quot    = fa_prod_reg[32:24];
    assign qr_full = {17'b0, quot} * {9'b0, RANGE17};
    assign rem_raw = fa_word_reg.heading - qr_full[11:0];

    always_comb
    begin
        mid_word = fa_word_reg;
        if ({5'b0, rem_raw} >= RANGE17)
        begin
            mid_word.heading = rem_raw - RANGE17[11:0];
        end
        else
        begin
            mid_word.heading = rem_raw;
        end
    end

    assign mid_push = va_reg;

endmodule

>>> hdl/hpdd_back.sv
// back end: controller state, pid products and wheel speed mixing
module hpdd_back #(
    parameter int HEADING_RANGE = 4096,
    parameter int CW            = 3
) (
    input  logic           clk,
    input  logic           rst_n,
    input  hpdd_pkg::cfg_t cfg,
    input  logic           mid_empty,
    input  hpdd_pkg::mid_t mid_word,
    output logic           mid_pop,
    input  logic [CW-1:0]  out_count,
    output logic           out_push,
    output hpdd_pkg::res_t out_word
);

    localparam int RB = $clog2(HEADING_RANGE + 1);
    localparam int DW = ((RB > 12) ? RB : 12) + 2;
    localparam logic signed [DW-1:0] HALF    = DW'(HEADING_RANGE / 2);
    localparam logic signed [DW-1:0] RANGE_S = DW'(HEADING_RANGE);

    // controller state
    logic [11:0]        target_reg, target_next;
    logic [11:0]        last_reg, last_next;
    logic [15:0]        sum_reg, sum_next;
    logic [15:0]        prev_reg, prev_next;
    logic [23:0]        dt_reg, dt_next;
    logic [23:0]        dc_reg, dc_next;
    logic               latch_reg, latch_next;
    logic               ended_reg, ended_next;

    // stage one
    logic               v1_reg;
    logic               s1_tick_reg, s1_drive_reg, s1_pid_reg, s1_lin_reg, s1_neg_reg;
    logic signed [15:0] s1_d_reg, s1_sum_reg;
    logic signed [16:0] s1_diff_reg;
    logic [3:0]         s1_flags_reg;

    // stage two
    logic               v2_reg;
    logic               s2_tick_reg, s2_drive_reg, s2_pid_reg, s2_lin_reg, s2_neg_reg;
    logic signed [31:0] s2_pp_reg, s2_pi_reg;
    logic signed [32:0] s2_pd_reg;
    logic [3:0]         s2_flags_reg;

    logic               issue, tick, drive, pid, lin_on, lin_neg;
    logic signed [DW-1:0] t_s, h_s, d_raw, d_w;
    logic [DW+15:0]     d_ext;
    logic signed [15:0] d16, sum16;
    logic signed [16:0] diff17;
    logic [23:0]        dt_abs, dc_inc;
    logic signed [12:0] rot_diff;
    logic [11:0]        rot_abs;
    logic [3:0]         flags;

    logic signed [34:0] acc, acc_adj;
    logic signed [26:0] tmp, lim27;
    logic signed [7:0]  corr, budget, mag, lin;
    logic [6:0]         corr_abs;
    logic signed [8:0]  right_s, left_s;

    assign issue = !mid_empty
                   && (({2'b0, out_count} + {{(CW+1){1'b0}}, v1_reg}
                        + {{(CW+1){1'b0}}, v2_reg}) < (CW + 2)'(hpdd_pkg::OUT_DEPTH));
    assign mid_pop = issue;
    assign tick = (mid_word.op == hpdd_pkg::OP_TICK);

    assign t_s   = {{(DW-12){1'b0}}, target_reg};
    assign h_s   = {{(DW-12){1'b0}}, mid_word.heading};
    assign d_raw = t_s - h_s;

    always_comb
    begin
        if (d_raw > HALF)
        begin
            d_w = d_raw - RANGE_S;
        end
        else if (d_raw < -HALF)
        begin
            d_w = d_raw + RANGE_S;
        end
        else
        begin
            d_w = d_raw;
        end
    end

    assign d_ext  = {{16{d_w[DW-1]}}, d_w};
    assign d16    = d_ext[15:0];
    assign sum16  = sum_reg + d16;
    assign diff17 = {d16[15], d16} - {prev_reg[15], prev_reg};
    assign dt_abs = dt_reg[23] ? (24'd0 - dt_reg) : dt_reg;
    assign dc_inc = dc_reg + 24'd1;

    always_comb
    begin
        target_next = target_reg;
        last_next   = last_reg;
        sum_next    = sum_reg;
        prev_next   = prev_reg;
        dt_next     = dt_reg;
        dc_next     = dc_reg;
        latch_next  = latch_reg;
        ended_next  = ended_reg;
        drive       = 1'b0;
        pid         = 1'b0;
        lin_on      = 1'b0;
        lin_neg     = dt_reg[23];
        unique case (mid_word.op)
            hpdd_pkg::OP_TICK:
            begin
                if (latch_reg && cfg.stop_enable)
                begin
                    latch_next = mid_word.obstacle;
                end
                else if (!ended_reg)
                begin
                    drive     = 1'b1;
                    last_next = mid_word.heading;
                    if (target_reg != mid_word.heading)
                    begin
                        pid       = 1'b1;
                        sum_next  = sum16;
                        prev_next = d16;
                    end
                    if (dt_reg != '0)
                    begin
                        lin_on  = 1'b1;
                        dc_next = dc_inc;
                        if (dc_inc == dt_abs)
                        begin
                            dt_next = '0;
                            dc_next = '0;
                        end
                    end
                end
            end
            hpdd_pkg::OP_HEAD: target_next = mid_word.heading;
            hpdd_pkg::OP_DIST: dt_next = mid_word.distance;
            hpdd_pkg::OP_STOP: latch_next = 1'b1;
            hpdd_pkg::OP_END:  ended_next = 1'b1;
            default: ;
        endcase
    end

    assign rot_diff = {1'b0, target_next} - {1'b0, last_next};
    assign rot_abs  = rot_diff[12] ? 12'(-rot_diff) : rot_diff[11:0];
    assign flags    = {dt_next == '0, rot_abs < cfg.heading_tolerance, ended_next, latch_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            last_reg   <= '0;
            sum_reg    <= '0;
            prev_reg   <= '0;
            dt_reg     <= '0;
            dc_reg     <= '0;
            latch_reg  <= 1'b1;
            ended_reg  <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                target_reg <= target_next;
                last_reg   <= last_next;
                sum_reg    <= sum_next;
                prev_reg   <= prev_next;
                dt_reg     <= dt_next;
                dc_reg     <= dc_next;
                latch_reg  <= latch_next;
                ended_reg  <= ended_next;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_tick_reg  <= tick;
            s1_drive_reg <= drive;
            s1_pid_reg   <= pid;
            s1_lin_reg   <= lin_on;
            s1_neg_reg   <= lin_neg;
            s1_d_reg     <= d16;
            s1_sum_reg   <= sum16;
            s1_diff_reg  <= diff17;
            s1_flags_reg <= flags;
        end
        if (v1_reg)
        begin
            s2_tick_reg  <= s1_tick_reg;
            s2_drive_reg <= s1_drive_reg;
            s2_pid_reg   <= s1_pid_reg;
            s2_lin_reg   <= s1_lin_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_flags_reg <= s1_flags_reg;
            s2_pp_reg    <= cfg.gain_prop * s1_d_reg;
            s2_pi_reg    <= cfg.gain_integ * s1_sum_reg;
            s2_pd_reg    <= {{17{cfg.gain_deriv[15]}}, cfg.gain_deriv}
                            * {{16{s1_diff_reg[16]}}, s1_diff_reg};
        end
    end

    // q8.8 sum, truncated toward zero
    assign acc = {{3{s2_pp_reg[31]}}, s2_pp_reg} + {{3{s2_pi_reg[31]}}, s2_pi_reg}
                 + {{2{s2_pd_reg[32]}}, s2_pd_reg};
    assign acc_adj = acc + (acc[34] ? 35'sd255 : 35'sd0);
    assign tmp     = acc_adj[34:8];
    assign lim27   = {20'b0, cfg.turn_speed_limit};

    always_comb
    begin
        if (!s2_pid_reg)
        begin
            corr = '0;
        end
        else if (tmp > lim27)
        begin
            corr = {1'b0, cfg.turn_speed_limit};
        end
        else if (tmp < -lim27)
        begin
            corr = -{1'b0, cfg.turn_speed_limit};
        end
        else
        begin
            corr = tmp[7:0];
        end
    end

    assign corr_abs = corr[7] ? 7'(-corr) : corr[6:0];
    assign budget   = {1'b0, cfg.top_speed} - {1'b0, corr_abs};
    assign mag      = ($signed({1'b0, cfg.cruise_speed}) < budget) ? {1'b0, cfg.cruise_speed}
                                                                   : budget;
    assign lin      = !s2_lin_reg ? 8'sd0 : (s2_neg_reg ? -mag : mag);
    assign right_s  = {lin[7], lin} - {corr[7], corr};
    assign left_s   = {lin[7], lin} + {corr[7], corr};

    always_comb
    begin
        out_word.right_speed      = s2_drive_reg ? right_s : 9'sd0;
        out_word.left_speed       = s2_drive_reg ? left_s : 9'sd0;
        out_word.speeds_valid     = s2_tick_reg;
        out_word.translation_done = s2_flags_reg[3];
        out_word.rotation_done    = s2_flags_reg[2];
        out_word.match_over       = s2_flags_reg[1];
        out_word.stop_active      = s2_flags_reg[0];
    end

    assign out_push = v2_reg;

endmodule

>>> hdl/heading_pid_differential_drive_core.sv
// top level of the heading pid differential drive core
// usage:
// - input channel: drive command and its fields with push; a word is taken
//   when push is high and full is low
// - result channel: a result word sits on the result ports while empty is
//   low and is taken when pop is high
// - configuration: write_enable with write_index and write_data; the user must
//   write only while the block is idle, the block itself does not enforce it
// - every command gives exactly one result word, in order
// - path: a taken word passes the front register, the internal queue, the state
//   update into stage one, the product stage two and then the result queue
// - throughput: one word per cycle unless the result queue backs up; the state
//   update of a tick registers at issue, the three gain products one stage behind
// - when pop stays low the result queue fills, the back end stops taking words
//   from the internal queue, and full rises once that queue is also full
// - reset: default gains and limits, stop latched, match running, targets and
//   pid history cleared, both queues empty
module heading_pid_differential_drive_core #(
    parameter int HEADING_RANGE = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         command,
    input  logic [11:0]        heading_now,
    input  logic               obstacle_seen,
    input  logic [11:0]        heading_goal,
    input  logic signed [23:0] distance_goal,
    output logic               empty,
    input  logic               pop,
    output logic signed [8:0]  right_speed,
    output logic signed [8:0]  left_speed,
    output logic               speeds_valid,
    output logic               translation_done,
    output logic               rotation_done,
    output logic               match_over,
    output logic               stop_active,
    input  logic               write_enable,
    input  logic [2:0]         write_index,
    input  logic [15:0]        write_data
);

`include "heading_pid_differential_drive_core_macros.svh"

    localparam logic [2:0] REG_STOP_ENABLE = 3'd0;
    localparam logic [2:0] REG_GAIN_PROP   = 3'd1;
    localparam logic [2:0] REG_GAIN_INTEG  = 3'd2;
    localparam logic [2:0] REG_GAIN_DERIV  = 3'd3;
    localparam logic [2:0] REG_TURN_LIMIT  = 3'd4;
    localparam logic [2:0] REG_CRUISE      = 3'd5;
    localparam logic [2:0] REG_TOP_SPEED   = 3'd6;
    localparam logic [2:0] REG_TOLERANCE   = 3'd7;

    localparam int MID_CW = $clog2(hpdd_pkg::MID_DEPTH + 1);
    localparam int OUT_CW = $clog2(hpdd_pkg::OUT_DEPTH + 1);

    hpdd_pkg::cfg_t cfg_reg, cfg_next;
    hpdd_pkg::mid_t mid_in, mid_out;
    hpdd_pkg::res_t res_in, res_out;
    logic              mid_push, mid_pop, mid_empty;
    logic [MID_CW-1:0] mid_count;
    logic              out_push;
    logic [OUT_CW-1:0] out_count;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (write_index)
                REG_STOP_ENABLE: cfg_next.stop_enable       = write_data[0];
                REG_GAIN_PROP:   cfg_next.gain_prop         = write_data;
                REG_GAIN_INTEG:  cfg_next.gain_integ        = write_data;
                REG_GAIN_DERIV:  cfg_next.gain_deriv        = write_data;
                REG_TURN_LIMIT:  cfg_next.turn_speed_limit  = write_data[6:0];
                REG_CRUISE:      cfg_next.cruise_speed      = write_data[6:0];
                REG_TOP_SPEED:   cfg_next.top_speed         = write_data[6:0];
                REG_TOLERANCE:   cfg_next.heading_tolerance = write_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_enable       <= 1'b1;
            cfg_reg.gain_prop         <= 16'sd51;
            cfg_reg.gain_integ        <= 16'sd0;
            cfg_reg.gain_deriv        <= 16'sd0;
            cfg_reg.turn_speed_limit  <= 7'd30;
            cfg_reg.cruise_speed      <= 7'd40;
            cfg_reg.top_speed         <= 7'd100;
            cfg_reg.heading_tolerance <= 12'd20;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hpdd_front #(
        .HEADING_RANGE(HEADING_RANGE),
        .CW(MID_CW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .command(command),
        .heading_now(heading_now),
        .obstacle_seen(obstacle_seen),
        .heading_goal(heading_goal),
        .distance_goal(distance_goal),
        .mid_count(mid_count),
        .mid_push(mid_push),
        .mid_word(mid_in)
    );

    hpdd_queue #(
        .WIDTH($bits(hpdd_pkg::mid_t)),
        .DEPTH(hpdd_pkg::MID_DEPTH)
    ) u_mid_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(mid_push),
        .wdata(mid_in),
        .pop(mid_pop),
        .rdata(mid_out),
        .empty(mid_empty),
        .count(mid_count)
    );

    hpdd_back #(
        .HEADING_RANGE(HEADING_RANGE),
        .CW(OUT_CW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .mid_empty(mid_empty),
        .mid_word(mid_out),
        .mid_pop(mid_pop),
        .out_count(out_count),
        .out_push(out_push),
        .out_word(res_in)
    );

    hpdd_queue #(
        .WIDTH($bits(hpdd_pkg::res_t)),
        .DEPTH(hpdd_pkg::OUT_DEPTH)
    ) u_out_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(out_push),
        .wdata(res_in),
        .pop(pop),
        .rdata(res_out),
        .empty(empty),
        .count(out_count)
    );

    assign right_speed      = res_out.right_speed;
    assign left_speed       = res_out.left_speed;
    assign speeds_valid     = res_out.speeds_valid;
    assign translation_done = res_out.translation_done;
    assign rotation_done    = res_out.rotation_done;
    assign match_over       = res_out.match_over;
    assign stop_active      = res_out.stop_active;

    `HPDD_ASSERT(a_mid_bound, mid_count <= MID_CW'(hpdd_pkg::MID_DEPTH), "internal queue overrun")
    `HPDD_ASSERT(a_out_bound, out_count <= OUT_CW'(hpdd_pkg::OUT_DEPTH), "result queue overrun")
    `HPDD_ASSERT(a_idle_zero, empty || speeds_valid || (right_speed == 9'sd0 && left_speed == 9'sd0), "non-tick word with speed")
    `HPDD_ASSERT_NEXT(a_drain, pop && !empty && out_count == OUT_CW'(1) && !out_push, empty, "result queue did not drain")

endmodule
